FILE: hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ORG_W  = 14;
  localparam int ADDR_W = 15;
  localparam int DATA_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  localparam int MAX_RES = 4;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 2;

  localparam logic [DATA_W-1:0]  COLS_WORD   = DATA_W'(SCREEN_COLUMNS);
  localparam logic [ROW_W:0]     ROWS_X      = (ROW_W+1)'(SCREEN_ROWS);
  localparam logic [COL_W:0]     COLS_X      = (COL_W+1)'(SCREEN_COLUMNS);
  localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [ORG_W:0]     LINE_STEP   = (ORG_W+1)'(SCREEN_COLUMNS);
  localparam logic [DATA_W-1:0]  FILL_OFFSET = DATA_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [COL_W-1:0]   PROMPT_COLS  = 7'd2;

  localparam logic [ATTR_W-1:0]  ATTR_RESET  = 8'd159;
  localparam logic [DATA_W-1:0]  BLANK_RESET = 16'd40704;
  localparam logic [ORG_W-1:0]   LIMIT_RESET = 14'd16383;

  typedef enum logic [2:0] {
    OP_PUT_CHAR    = 3'd0,
    OP_BACKSPACE   = 3'd1,
    OP_SCROLL_UP   = 3'd2,
    OP_SCROLL_DOWN = 3'd3,
    OP_ARROW       = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } arrow_e;

  typedef enum logic [1:0] {
    KIND_CELL   = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_ORIGIN = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ATTR  = 2'd0,
    CFG_BLANK = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [DATA_W-1:0] blank;
    logic [ORG_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ORG_W-1:0] origin;
  } cur_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } res_t;

endpackage

FILE: hw/rtl/tcce_step.sv
`timescale 1ns / 1ps

module tcce_step import tcce_pkg::*; (
  input  cur_t                   cur_i,
  input  cfg_t                   cfg_i,
  input  logic [2:0]             opcode_i,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [1:0]             arrow_dir_i,
  output cur_t                   cur_o,
  output res_t [MAX_RES-1:0]     res_o,
  output logic [CNT_W-1:0]       count_o
);

  function automatic logic [DATA_W-1:0] cursor_word(logic [ORG_W-1:0] origin,
                                                    logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
    return DATA_W'(origin) + DATA_W'(row) * COLS_WORD + DATA_W'(col);
  endfunction

  // Wrap to zero beyond the limit
  function automatic logic [ORG_W-1:0] fix_origin(logic [ORG_W:0] o, logic [ORG_W-1:0] lim);
    return (o > (ORG_W+1)'(lim)) ? '0 : o[ORG_W-1:0];
  endfunction

  always_comb begin
    logic [ROW_W:0]   row_n;
    logic [COL_W:0]   col_n;
    logic [ORG_W-1:0] org_n;
    logic [CNT_W-1:0] n;
    logic             valid_op;

    row_n    = (ROW_W+1)'(cur_i.row);
    col_n    = (COL_W+1)'(cur_i.col);
    org_n    = cur_i.origin;
    n        = '0;
    valid_op = 1'b1;
    res_o    = '0;

    unique case (opcode_e'(opcode_i))
      OP_PUT_CHAR: begin
        if (char_code_i == CHAR_NEWLINE) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end else begin
          res_o[n[IDX_W-1:0]].kind    = KIND_CELL;
          res_o[n[IDX_W-1:0]].address =
            ADDR_W'(cursor_word(cur_i.origin, cur_i.row, cur_i.col));
          res_o[n[IDX_W-1:0]].data    = {cfg_i.attr, char_code_i};
          n     = n + 1'b1;
          col_n = col_n + 1'b1;
        end
        if (col_n >= COLS_X) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end
        if (row_n >= ROWS_X) begin
          org_n = fix_origin((ORG_W+1)'(cur_i.origin) + LINE_STEP, cfg_i.limit);
          res_o[n[IDX_W-1:0]].kind    = KIND_ORIGIN;
          res_o[n[IDX_W-1:0]].address = '0;
          res_o[n[IDX_W-1:0]].data    = DATA_W'(org_n);
          n = n + 1'b1;
          res_o[n[IDX_W-1:0]].kind    = KIND_FILL;
          res_o[n[IDX_W-1:0]].address = ADDR_W'(DATA_W'(org_n) + FILL_OFFSET);
          res_o[n[IDX_W-1:0]].data    = cfg_i.blank;
          n     = n + 1'b1;
          row_n = (ROW_W+1)'(LAST_ROW);
          col_n = '0;
        end
      end
      OP_BACKSPACE: begin
        if (cur_i.col > PROMPT_COLS) begin
          col_n = col_n - 1'b1;
          res_o[n[IDX_W-1:0]].kind    = KIND_CELL;
          res_o[n[IDX_W-1:0]].address =
            ADDR_W'(cursor_word(cur_i.origin, cur_i.row, col_n[COL_W-1:0]));
          res_o[n[IDX_W-1:0]].data    = cfg_i.blank;
          n = n + 1'b1;
        end
      end
      OP_SCROLL_UP: begin
        org_n = fix_origin((ORG_W+1)'(cur_i.origin) + LINE_STEP, cfg_i.limit);
        res_o[n[IDX_W-1:0]].kind    = KIND_ORIGIN;
        res_o[n[IDX_W-1:0]].address = '0;
        res_o[n[IDX_W-1:0]].data    = DATA_W'(org_n);
        n = n + 1'b1;
      end
      OP_SCROLL_DOWN: begin
        if ((ORG_W+1)'(cur_i.origin) >= LINE_STEP) begin
          org_n = fix_origin((ORG_W+1)'(cur_i.origin) - LINE_STEP, cfg_i.limit);
        end else begin
          org_n = '0;
        end
        res_o[n[IDX_W-1:0]].kind    = KIND_ORIGIN;
        res_o[n[IDX_W-1:0]].address = '0;
        res_o[n[IDX_W-1:0]].data    = DATA_W'(org_n);
        n = n + 1'b1;
      end
      OP_ARROW: begin
        case (arrow_e'(arrow_dir_i))
          DIR_UP:    if (row_n != '0) row_n = row_n - 1'b1;
          DIR_DOWN:  if (row_n + 1'b1 < ROWS_X) row_n = row_n + 1'b1;
          DIR_LEFT:  if (col_n != '0) col_n = col_n - 1'b1;
          default:   if (col_n + 1'b1 < COLS_X) col_n = col_n + 1'b1;
        endcase
      end
      default: valid_op = 1'b0;
    endcase

    if (valid_op) begin
      res_o[n[IDX_W-1:0]].kind    = KIND_CURSOR;
      res_o[n[IDX_W-1:0]].address = '0;
      res_o[n[IDX_W-1:0]].data    =
        cursor_word(org_n, row_n[ROW_W-1:0], col_n[COL_W-1:0]);
      n = n + 1'b1;
    end

    cur_o.row    = row_n[ROW_W-1:0];
    cur_o.col    = col_n[COL_W-1:0];
    cur_o.origin = org_n;
    count_o      = n;
  end

endmodule

FILE: hw/rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps

// Text console cursor engine for an 80 x 25 screen in word-addressed video memory.
// Input channel (in_valid_i / in_stall_o): one word per key action, made of opcode,
// character code and arrow direction. Output channel (out_valid_o / out_stall_i):
// the video and register writes each action causes, one word per handshake:
// cell writes, line fills, origin register and cursor register values, with
// last_o marking the final word of an action (always the cursor write).
// Configuration: cfg_we_i writes attribute byte, blank word or origin limit,
// selected by cfg_idx_i; write only while the block is idle.
// The first output word of an action passes through the input register, the result
// bundle register and the output register. An action makes 1 to 4 results (invalid
// opcodes make none); the result drainer sends one word a cycle while the output is
// not stalled, and the next action loads as the last word of the bundle leaves.
// Reset clears cursor row, column and scroll origin, loads the register reset
// values and empties all stages. A stall on the output holds the output word;
// the pending result bundle and then the input register fill and in_stall_o rises.
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           opcode_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [1:0]           arrow_dir_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [ADDR_W-1:0]    address_o,
  output logic [DATA_W-1:0]    data_o,
  output logic                 last_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  // Input register
  logic              in_valid_q;
  logic [2:0]        op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [1:0]        dir_q;

  // Cursor state and configuration
  cur_t cur_q, cur_d;
  cfg_t cfg_q;

  // Result bundle of one action, drained one word a cycle while the output is not stalled
  res_t [MAX_RES-1:0] res_q, res_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   rd_q;

  // Output register
  logic              out_valid_q;
  res_t              out_q;
  logic              out_last_q;

  logic in_accept, load, pending, take, bundle_free, take_last;

  tcce_step u_step (
    .cur_i       (cur_q),
    .cfg_i       (cfg_q),
    .opcode_i    (op_q),
    .char_code_i (ch_q),
    .arrow_dir_i (dir_q),
    .cur_o       (cur_d),
    .res_o       (res_d),
    .count_o     (cnt_d)
  );

  assign pending     = (rd_q != cnt_q);
  assign take        = pending && (!out_valid_q || !out_stall_i);
  assign take_last   = (rd_q + 1'b1) == cnt_q;
  // The bundle frees when empty, or when its final word moves out this cycle
  assign bundle_free = !pending || (take && take_last);
  assign load        = in_valid_q && bundle_free;
  assign in_stall_o  = in_valid_q && !load;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      cfg_q.attr  <= ATTR_RESET;
      cfg_q.blank <= BLANK_RESET;
      cfg_q.limit <= LIMIT_RESET;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end

      // A load restarts the bundle even when its last word leaves this cycle
      if (load) begin
        cur_q <= cur_d;
        cnt_q <= cnt_d;
        rd_q  <= '0;
      end else if (take) begin
        rd_q <= rd_q + 1'b1;
      end

      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ATTR:  cfg_q.attr  <= cfg_wdata_i[ATTR_W-1:0];
          CFG_BLANK: cfg_q.blank <= cfg_wdata_i;
          CFG_LIMIT: cfg_q.limit <= cfg_wdata_i[ORG_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= opcode_i;
      ch_q  <= char_code_i;
      dir_q <= arrow_dir_i;
    end
    if (load) begin
      res_q <= res_d;
    end
    if (take) begin
      out_q      <= res_q[rd_q[IDX_W-1:0]];
      out_last_q <= take_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign address_o   = out_q.address;
  assign data_o      = out_q.data;
  assign last_o      = out_last_q;

endmodule
